// File: rtl/three_axis_rate_pid_top_defines.svh
// Assertion helpers shared by the checker.
`ifndef THREE_AXIS_RATE_PID_TOP_DEFINES_SVH
`define THREE_AXIS_RATE_PID_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/trp_pkg.sv
`timescale 1ns / 1ps
package trp_pkg;

  localparam logic [2:0] CFG_FLIGHT_MODE = 3'd0;
  localparam logic [2:0] CFG_RATE_P      = 3'd1;
  localparam logic [2:0] CFG_RATE_I      = 3'd2;
  localparam logic [2:0] CFG_RATE_D      = 3'd3;
  localparam logic [2:0] CFG_LEVEL       = 3'd4;

  localparam logic [2:0] MODE_ZERO     = 3'd3;
  localparam logic [2:0] MODE_SETPOINT = 3'd4;
  localparam logic [2:0] MODE_GYRO     = 3'd5;

  localparam logic [1:0] AXIS_ROLL = 2'd0;
  localparam logic [1:0] AXIS_YAW  = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Dividing by 10000 is a shift by four, then a multiply by ceil(2^38 / 625)
  // and a shift by 38, which is exact for every 28-bit operand.
  localparam logic [28:0] IntegRecip = 29'd439804652;
  localparam logic [15:0] DScaleNum  = 16'hFFFF;
  localparam logic signed [29:0] IntegLimit = 30'sd4096000;
  localparam logic signed [31:0] DriveMax   = 32'sd32767;
  localparam logic signed [31:0] DriveMin   = -32'sd32768;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LEVEL,
    OP_ERR,
    OP_PMUL,
    OP_IMUL,
    OP_IDIV,
    OP_IGAIN,
    OP_IACC,
    OP_DDIV,
    OP_DMUL,
    OP_DSUM,
    OP_DGAIN,
    OP_TOTAL
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic axis_bad;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/trp_div.sv
`timescale 1ns / 1ps
module trp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic [15:0] quotient_o,
  output logic        done_o
);
  localparam logic [4:0] Steps = 5'd16;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [15:0] rem_q, dvs_q;
  logic [15:0] sh_q;
  logic [16:0] shifted, trial;
  logic        fits;

  always_comb begin
    shifted = {rem_q, sh_q[15]};
    trial   = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= Steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sh_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[15:0] : shifted[15:0];
      sh_q  <= {sh_q[14:0], fits};
    end
  end

  assign quotient_o = sh_q;
  assign done_o     = done_q;
endmodule

// File: rtl/trp_datapath.sv
`timescale 1ns / 1ps
module trp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trp_pkg::cmd_t       cmd_i,
  output trp_pkg::status_t    status_o,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic [1:0]          axis_index_i,
  input  logic signed [13:0]  gyro_rate_i,
  input  logic signed [11:0]  attitude_angle_i,
  input  logic signed [9:0]   setpoint_i,
  input  logic [15:0]         cycle_time_i,
  input  logic                clear_integrators_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  drive_value_o
);
  import trp_pkg::*;

  logic [2:0] mode_q;
  logic [7:0] pg_q, ig_q, dg_q, lg_q;

  logic [1:0]         axis_q;
  logic signed [13:0] gyro_q;
  logic signed [11:0] angle_q;
  logic signed [9:0]  sp_q;
  logic [15:0]        ct_q;

  logic signed [23:0] integ_q [3];
  logic signed [16:0] prev_q  [3];
  logic signed [27:0] tap1_q  [3];
  logic signed [27:0] tap2_q  [3];

  logic signed [21:0] lvl_q;
  logic signed [16:0] err_q;
  logic signed [17:0] p_q, ddiff_q;
  logic signed [32:0] ic_q;
  logic [18:0]        iquo_q;
  logic signed [28:0] igp_q;
  logic signed [9:0]  iterm_q;
  logic signed [27:0] d_q;
  logic signed [29:0] dsum_q, dterm_q;
  logic               out_valid_q;
  logic signed [15:0] drive_q;

  logic signed [10:0] want;
  logic signed [12:0] lvl_diff;
  logic signed [21:0] lvl_prod;
  logic signed [17:0] target;
  logic signed [18:0] err_wide;
  logic signed [25:0] p_prod;
  logic signed [17:0] ddiff_next;
  logic signed [32:0] ic_prod;
  logic [31:0]        ic_mag;
  logic [56:0]        iq_prod;
  logic signed [19:0] iq;
  logic signed [28:0] ig_prod;
  logic signed [29:0] acc_sum, acc_clamp;
  logic signed [33:0] d_prod;
  logic signed [29:0] dsum_next;
  logic signed [37:0] dg_prod;
  logic signed [31:0] total;
  logic signed [15:0] drive_next;
  logic [15:0]        ddiv;
  logic               div_start, div_done;
  logic [15:0]        quo;

  always_comb begin
    want     = (axis_q == AXIS_ROLL) ? 11'(sp_q) + 11'sd10 : 11'(sp_q);
    lvl_diff = 13'(want) - 13'(angle_q);
    lvl_prod = 22'(lvl_diff) * 22'($signed({1'b0, lg_q}));

    if (axis_q == AXIS_YAW || mode_q == MODE_ZERO) begin
      target = '0;
    end else begin
      case (mode_q)
        MODE_SETPOINT: target = 18'(want) <<< 2;
        MODE_GYRO:     target = 18'(gyro_q);
        default:       target = 18'(lvl_q >>> 4);
      endcase
    end
    err_wide = 19'(target) - 19'(gyro_q);

    p_prod     = 26'(err_q) * 26'($signed({1'b0, pg_q}));
    ddiff_next = 18'(err_q) - 18'(prev_q[axis_q]);
    ic_prod    = 33'(err_q) * 33'($signed({1'b0, ct_q}));
    ic_mag     = ic_q[32] ? 32'(-ic_q) : ic_q[31:0];
    iq_prod    = 57'(ic_mag[31:4]) * 57'(IntegRecip);

    // The integrator step truncates toward zero, so divide the magnitude.
    iq      = $signed({1'b0, iquo_q});
    if (ic_q[32]) begin
      iq = -iq;
    end
    ig_prod = 29'(iq) * 29'($signed({1'b0, ig_q}));

    acc_sum = 30'(integ_q[axis_q]) + 30'(igp_q);
    if (acc_sum > IntegLimit) begin
      acc_clamp = IntegLimit;
    end else if (acc_sum < -IntegLimit) begin
      acc_clamp = -IntegLimit;
    end else begin
      acc_clamp = acc_sum;
    end

    ddiv      = (ct_q[15:4] == 12'd0) ? 16'd1 : {4'b0000, ct_q[15:4]};
    d_prod    = 34'(ddiff_q) * 34'($signed({1'b0, quo}));
    dsum_next = 30'(d_q) + 30'(tap1_q[axis_q]) + 30'(tap2_q[axis_q]);
    dg_prod   = 38'(dsum_q) * 38'($signed({1'b0, dg_q}));

    total = 32'(p_q) + 32'(iterm_q) + 32'(dterm_q);
    if (total > DriveMax) begin
      drive_next = 16'sh7FFF;
    end else if (total < DriveMin) begin
      drive_next = 16'sh8000;
    end else begin
      drive_next = total[15:0];
    end

    div_start = (cmd_i.op == OP_DDIV);
  end

  trp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DScaleNum),
    .divisor_i  (ddiv),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 3'd0;
      pg_q   <= 8'd20;
      ig_q   <= 8'd20;
      dg_q   <= 8'd10;
      lg_q   <= 8'd9;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FLIGHT_MODE: mode_q <= cfg_data_i[2:0];
        CFG_RATE_P:      pg_q   <= cfg_data_i;
        CFG_RATE_I:      ig_q   <= cfg_data_i;
        CFG_RATE_D:      dg_q   <= cfg_data_i;
        CFG_LEVEL:       lg_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        integ_q[i] <= '0;
        prev_q[i]  <= '0;
        tap1_q[i]  <= '0;
        tap2_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.load && clear_integrators_i) begin
        for (int i = 0; i < 3; i++) begin
          integ_q[i] <= '0;
        end
      end
      if (cmd_i.op == OP_IACC) begin
        integ_q[axis_q] <= acc_clamp[23:0];
      end
      if (cmd_i.op == OP_DSUM) begin
        tap2_q[axis_q] <= tap1_q[axis_q];
        tap1_q[axis_q] <= d_q;
        prev_q[axis_q] <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      axis_q  <= axis_index_i;
      gyro_q  <= gyro_rate_i;
      angle_q <= attitude_angle_i;
      sp_q    <= setpoint_i;
      ct_q    <= cycle_time_i;
    end
    unique case (cmd_i.op)
      OP_LEVEL: lvl_q <= lvl_prod;
      OP_ERR:   err_q <= err_wide[16:0];
      OP_PMUL: begin
        p_q     <= p_prod[24:7];
        ddiff_q <= ddiff_next;
      end
      OP_IMUL:  ic_q    <= ic_prod;
      OP_IDIV:  iquo_q  <= iq_prod[56:38];
      OP_IGAIN: igp_q   <= ig_prod;
      OP_IACC:  iterm_q <= acc_clamp[22:13];
      OP_DMUL:  d_q     <= d_prod[33:6];
      OP_DSUM:  dsum_q  <= dsum_next;
      OP_DGAIN: dterm_q <= dg_prod[37:8];
      OP_TOTAL: drive_q <= drive_next;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_TOTAL) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.axis_bad = (axis_q == AXIS_NONE);
  assign status_o.div_done = div_done;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;
endmodule

// File: rtl/trp_ctrl.sv
`timescale 1ns / 1ps
module trp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  trp_pkg::status_t status_i,
  output trp_pkg::cmd_t    cmd_o
);
  import trp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LEVEL, S_ERR, S_PMUL, S_IMUL, S_IDIV, S_IGAIN,
    S_IACC, S_DDIV, S_DWAIT, S_DMUL, S_DSUM, S_DGAIN, S_TOTAL
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_LEVEL;
        // An item for the unused axis code ends here without a result.
        S_LEVEL: state_q <= status_i.axis_bad ? S_IDLE : S_ERR;
        S_ERR:   state_q <= S_PMUL;
        S_PMUL:  state_q <= S_IMUL;
        S_IMUL:  state_q <= S_IDIV;
        S_IDIV:  state_q <= S_IGAIN;
        S_IGAIN: state_q <= S_IACC;
        S_IACC:  state_q <= S_DDIV;
        S_DDIV:  state_q <= S_DWAIT;
        S_DWAIT: if (status_i.div_done) state_q <= S_DMUL;
        S_DMUL:  state_q <= S_DSUM;
        S_DSUM:  state_q <= S_DGAIN;
        S_DGAIN: state_q <= S_TOTAL;
        S_TOTAL: if (!status_i.out_busy) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    unique case (state_q)
      S_LEVEL: cmd_o.op = OP_LEVEL;
      S_ERR:   cmd_o.op = OP_ERR;
      S_PMUL:  cmd_o.op = OP_PMUL;
      S_IMUL:  cmd_o.op = OP_IMUL;
      S_IDIV:  cmd_o.op = OP_IDIV;
      S_IGAIN: cmd_o.op = OP_IGAIN;
      S_IACC:  cmd_o.op = OP_IACC;
      S_DDIV:  cmd_o.op = OP_DDIV;
      S_DMUL:  cmd_o.op = OP_DMUL;
      S_DSUM:  cmd_o.op = OP_DSUM;
      S_DGAIN: cmd_o.op = OP_DGAIN;
      S_TOTAL: cmd_o.op = status_i.out_busy ? OP_NONE : OP_TOTAL;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
endmodule

// File: rtl/three_axis_rate_pid_top.sv
`timescale 1ns / 1ps
// Rate PID for three axes, one axis sample per input beat.
// Input channel: in_valid_i/in_ready_o with axis, gyro rate, angle, setpoint,
// cycle time and an integrator-clear flag. Output channel: out_valid_o/
// out_ready_i carrying the saturated 16-bit drive value for that axis.
// Configuration channel: cfg_valid_i/cfg_ready_o with a register index
// (0 flight mode, 1 P gain, 2 I gain, 3 D gain, 4 level gain) and data;
// it is always ready and should be written only while the block is idle.
// One item is worked at a time. The time from accept to result valid is
// set mostly by the 16-step shift-subtract divider for the derivative
// scale; the integrator increment uses a reciprocal multiply. The input
// is ready again in the same cycle that the result becomes valid. A
// sample for axis code three clears integrators if asked, gives no
// result and frees the input again after its level step.
// If the receiver stalls, the finished result is held in the output
// register; a following item is accepted and computed, then waits in its
// last step until the output register frees up.
// Reset restores the default gains and clears all integrators, previous
// errors and derivative taps.
module three_axis_rate_pid_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         axis_index_i,
  input  logic signed [13:0] gyro_rate_i,
  input  logic signed [11:0] attitude_angle_i,
  input  logic signed [9:0]  setpoint_i,
  input  logic [15:0]        cycle_time_i,
  input  logic               clear_integrators_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] drive_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import trp_pkg::*;

  cmd_t    cmd;
  status_t status;

  trp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  trp_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .axis_index_i        (axis_index_i),
    .gyro_rate_i         (gyro_rate_i),
    .attitude_angle_i    (attitude_angle_i),
    .setpoint_i          (setpoint_i),
    .cycle_time_i        (cycle_time_i),
    .clear_integrators_i (clear_integrators_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .drive_value_o       (drive_value_o)
  );

  assign cfg_ready_o = 1'b1;
endmodule

// File: rtl/trp_checker.sv
`timescale 1ns / 1ps
`include "three_axis_rate_pid_top_defines.svh"
module trp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] drive_value_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o
);
  // One item at a time: the input closes right after a beat is taken.
  `TRP_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "input reopened early")

  // A result never appears the cycle right after its input beat.
  `TRP_ASSERT_NOW(a_no_instant_result, $rose(out_valid_o), !$past(in_valid_i && in_ready_o), "result too early")

  // A stalled result holds its value.
  `TRP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(drive_value_o), "stalled result changed")

  // Configuration writes are never back-pressured.
  `TRP_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o, "configuration stalled")
endmodule

bind three_axis_rate_pid_top trp_checker u_trp_checker (.*);
